>>> src/etfp_pkg.sv
// etfp_pkg: shared widths, constants, register codes and command/status types
// for the escape-time fractal pixel block. No dependencies.
package etfp_pkg;

  // fixed-point format of the complex plane
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 44;                  // holds c and z after one update
  localparam int MUL_W     = 32;                  // multiplier operand width
  localparam int SQ_W      = 2 * MUL_W - FRAC_BITS;

  // port field widths
  localparam int IN_W      = 10;
  localparam int ORIGIN_W  = 32;
  localparam int STEP_W    = 31;
  localparam int PROD_W    = IN_W + STEP_W;
  localparam int GRAY_W    = 8;
  localparam int ITER_W    = 9;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORIGIN_RE = 2'd0,
    REG_ORIGIN_IM = 2'd1,
    REG_STEP_RE   = 2'd2,
    REG_STEP_IM   = 2'd3
  } cfg_reg_t;

  localparam logic [ORIGIN_W-1:0] ORIGIN_RE_RST = 32'hD800_0000;  // -2.5
  localparam logic [ORIGIN_W-1:0] ORIGIN_IM_RST = 32'h1400_0000;  // 1.25
  localparam logic [STEP_W-1:0]   STEP_RE_RST   = 31'd1048576;
  localparam logic [STEP_W-1:0]   STEP_IM_RST   = 31'd655360;

  // escape radius squared, 4.0
  localparam logic [SQ_W:0] FOUR = (SQ_W + 1)'(64'd4 << FRAC_BITS);

  // default iteration limit
  localparam int DEF_MAX_ITER = 500;

  // gray level: largest k with (2k-1)^2 * iteration limit <= 4 * 255^2 * n
  localparam int RHS_W = 32;
  localparam logic [RHS_W-1:0] RHS_SCALE = 32'd260100;

  typedef logic [255:0][RHS_W-1:0] thr_tab_t;

  function automatic thr_tab_t gray_thr_table(input int unsigned iter_cap);
    thr_tab_t    tab;
    logic [63:0] t;
    tab[0] = '0;
    for (int k = 1; k < 256; k++) begin
      t      = 64'(2 * k - 1);
      tab[k] = RHS_W'(t * t * 64'(iter_cap));
    end
    return tab;
  endfunction

  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_re;
    logic [ORIGIN_W-1:0] origin_im;
    logic [STEP_W-1:0]   step_re;
    logic [STEP_W-1:0]   step_im;
  } cfg_regs_t;

  // controller to datapath
  typedef struct packed {
    logic       load;       // form column and row products
    logic       setup;      // form c, clear z and count
    logic       iterate;    // cross product, new real part, count up
    logic       update;     // write back z
    logic       square;     // squares of z and range check
    logic       finish;     // latch limit flag and gray scale
    logic       gray_step;  // one bit of the gray search
    logic [2:0] gray_bit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;             // escaped or limit reached
  } dp_status_t;

endpackage

>>> src/escape_time_fractal_pixel.sv
// escape_time_fractal_pixel: top level, Mandelbrot escape-time pixel engine
// depends on etfp_pkg, etfp_cfg, etfp_ctrl, etfp_dpath
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   input     start && !busy       in_column, in_row
//   result    out_valid (1 cycle)  out_gray, out_iterations, out_in_set
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From the accepting edge to the result strobe, the setup state forms c,
// each iteration runs square, test and update through the 32x32
// multipliers, the last test ends the loop and an 8-step binary search
// finds the gray level. A new pixel is accepted during the strobe cycle.
// Reset is synchronous and loads the default view; there
// is no clearing pass. The result is shown for one cycle and is not held.
module escape_time_fractal_pixel
  import etfp_pkg::*;
#(
  parameter int MAX_ITER = DEF_MAX_ITER
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel command
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_W-1:0]       in_column,
  input  logic [IN_W-1:0]       in_row,
  // result strobe
  output logic                  out_valid,
  output logic [GRAY_W-1:0]     out_gray,
  output logic [ITER_W-1:0]     out_iterations,
  output logic                  out_in_set,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t  regs;
  dp_cmd_t    cmd;
  dp_status_t st;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;

  etfp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  etfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  etfp_dpath #(
    .MAX_ITER (MAX_ITER)
  ) u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .st             (st),
    .cfg            (regs),
    .in_column      (in_column),
    .in_row         (in_row),
    .out_gray       (out_gray),
    .out_iterations (out_iterations),
    .out_in_set     (out_in_set)
  );

  // accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // result strobe lasts a single cycle
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result only follows work in progress
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // a point in the set reports the full iteration count and black
  a_in_set_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_set |-> out_iterations == ITER_W'(MAX_ITER) && out_gray == '0)
    else $error("in-set result with wrong count or gray level");

endmodule

>>> src/etfp_cfg.sv
// etfp_cfg: configuration register file (view origin and pixel steps)
// depends on etfp_pkg
module etfp_cfg
  import etfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  // register write transaction, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.origin_re <= ORIGIN_RE_RST;
      regs_r.origin_im <= ORIGIN_IM_RST;
      regs_r.step_re   <= STEP_RE_RST;
      regs_r.step_im   <= STEP_IM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_RE: regs_r.origin_re <= cfg_data[ORIGIN_W-1:0];
        REG_ORIGIN_IM: regs_r.origin_im <= cfg_data[ORIGIN_W-1:0];
        REG_STEP_RE:   regs_r.step_re   <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:   regs_r.step_im   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

>>> src/etfp_ctrl.sv
// etfp_ctrl: sequencer for setup, the three-step iteration loop and the
// gray level search; depends on etfp_pkg
module etfp_ctrl
  import etfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t st,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_TEST,
    S_UPDATE,
    S_SQUARE,
    S_GRAY
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] gbit_r, gbit_nxt;
  logic       busy_r, busy_nxt;
  logic       valid_r, valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    gbit_nxt  = gbit_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    cmd.gray_bit = gbit_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (st.done) begin
          cmd.finish = 1'b1;
          gbit_nxt   = 3'd7;
          state_nxt  = S_GRAY;
        end else begin
          cmd.iterate = 1'b1;
          state_nxt   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_TEST;
      end
      S_GRAY: begin
        cmd.gray_step = 1'b1;
        gbit_nxt      = gbit_r - 3'd1;
        if (gbit_r == 3'd0) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gbit_r  <= 3'd0;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gbit_r  <= gbit_nxt;
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

>>> src/etfp_dpath.sv
// etfp_dpath: point forming, z*z + c iteration with 32x32 multipliers,
// escape test, iteration count and gray level search; depends on etfp_pkg
module etfp_dpath
  import etfp_pkg::*;
#(
  parameter int MAX_ITER = DEF_MAX_ITER
)(
  input  logic              clk,
  input  dp_cmd_t           cmd,
  output dp_status_t        st,
  input  cfg_regs_t         cfg,
  input  logic [IN_W-1:0]   in_column,
  input  logic [IN_W-1:0]   in_row,
  output logic [GRAY_W-1:0] out_gray,
  output logic [ITER_W-1:0] out_iterations,
  output logic              out_in_set
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam thr_tab_t GRAY_THR = gray_thr_table(MAX_ITER);

  logic [PROD_W-1:0]         mre_r, mim_r;
  logic signed [COORD_W-1:0] cre_r, cim_r;
  logic signed [COORD_W-1:0] zr_r, zi_r, nre_r;
  logic [SQ_W-1:0]           sq_re_r, sq_im_r;
  logic signed [SQ_W-1:0]    p_r;
  logic                      big_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      hit_r;
  logic [RHS_W-1:0]          rhs_r;
  logic [GRAY_W-1:0]         gray_r;

  logic signed [MUL_W-1:0]   zr_m, zi_m;
  logic signed [2*MUL_W-1:0] prod_rr, prod_ii, prod_ri;
  logic                      fit_re, fit_im;
  logic [SQ_W:0]             mag2;
  logic signed [SQ_W:0]      sq_diff;
  logic [GRAY_W-1:0]         cand;

  // multiplier operands, valid while z fits in 32 bits
  assign zr_m    = zr_r[MUL_W-1:0];
  assign zi_m    = zi_r[MUL_W-1:0];
  assign prod_rr = zr_m * zr_m;
  assign prod_ii = zi_m * zi_m;
  assign prod_ri = zr_m * zi_m;

  // a part of z beyond 32 bits squares far past the radius
  assign fit_re = (&zr_r[COORD_W-1:MUL_W-1]) || !(|zr_r[COORD_W-1:MUL_W-1]);
  assign fit_im = (&zi_r[COORD_W-1:MUL_W-1]) || !(|zi_r[COORD_W-1:MUL_W-1]);

  // escape test
  assign mag2    = {1'b0, sq_re_r} + {1'b0, sq_im_r};
  assign sq_diff = $signed({1'b0, sq_re_r}) - $signed({1'b0, sq_im_r});
  assign st.done = big_r || (mag2 > FOUR) || (cnt_r == CNT_W'(MAX_ITER));

  // candidate gray level for this search bit
  assign cand = gray_r | (GRAY_W'(1) << cmd.gray_bit);

  always_ff @(posedge clk) begin
    // column and row products at accept
    if (cmd.load) begin
      mre_r <= PROD_W'(in_column) * PROD_W'(cfg.step_re);
      mim_r <= PROD_W'(in_row) * PROD_W'(cfg.step_im);
    end
    // point c, z = 0
    if (cmd.setup) begin
      cre_r   <= COORD_W'($signed(cfg.origin_re)) + $signed(COORD_W'(mre_r));
      cim_r   <= COORD_W'($signed(cfg.origin_im)) - $signed(COORD_W'(mim_r));
      zr_r    <= '0;
      zi_r    <= '0;
      sq_re_r <= '0;
      sq_im_r <= '0;
      big_r   <= 1'b0;
      cnt_r   <= '0;
    end
    // cross product and new real part
    if (cmd.iterate) begin
      p_r   <= prod_ri[2*MUL_W-1:FRAC_BITS];
      nre_r <= COORD_W'(sq_diff) + cre_r;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    // z write back, imaginary part 2*re*im + c_im
    if (cmd.update) begin
      zr_r <= nre_r;
      zi_r <= (COORD_W'(p_r) <<< 1) + cim_r;
    end
    // squares, floored by the fraction shift
    if (cmd.square) begin
      sq_re_r <= prod_rr[2*MUL_W-1:FRAC_BITS];
      sq_im_r <= prod_ii[2*MUL_W-1:FRAC_BITS];
      big_r   <= !(fit_re && fit_im);
    end
    // result flag and gray search scale
    if (cmd.finish) begin
      hit_r  <= (cnt_r == CNT_W'(MAX_ITER));
      rhs_r  <= RHS_SCALE * RHS_W'(cnt_r);
      gray_r <= '0;
    end
    // binary search, msb first
    if (cmd.gray_step) begin
      if (GRAY_THR[cand] <= rhs_r) begin
        gray_r <= cand;
      end
    end
  end

  assign out_gray       = hit_r ? '0 : gray_r;
  assign out_iterations = ITER_W'(cnt_r);
  assign out_in_set     = hit_r;

endmodule
